FILE: src/mspc_pkg.sv
package mspc_pkg;

	// slot bank size and field widths
	localparam int SLOT_COUNT = 12;
	localparam int SLOT_W     = 4;
	localparam int NOTE_W     = 10;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// slot modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ARMED = 2'd1;
	localparam logic [1:0] MODE_REC   = 2'd2;
	localparam logic [1:0] MODE_PLAY  = 2'd3;

	// register indexes (word address)
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_CHANNEL   = 3'd1;
	localparam logic [2:0] REG_OCTAVE    = 3'd2;
	localparam logic [2:0] REG_REC_BASE  = 3'd3;
	localparam logic [2:0] REG_PLAY_BASE = 3'd4;

	// event op codes
	localparam logic OP_NOTE_ON  = 1'b0;
	localparam logic OP_NOTE_OFF = 1'b1;

	typedef logic [1:0]        mode_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic       op;
		logic [4:0] channel;
		logic [6:0] note_number;
		logic [6:0] velocity;
	} event_t;

	typedef struct packed {
		logic       start_rec;
		logic       stop_rec;
		slot_t      rec_slot;
		logic       stop_play;
		logic       start_play;
		slot_t      play_slot;
		logic       play_active;
		slot_t      active_slot;
		logic       passthrough;
	} result_t;

	typedef struct packed {
		logic       enable;
		logic [4:0] listen_channel;
		logic [3:0] octave_shift;
		logic [6:0] rec_note_base;
		logic [6:0] play_note_base;
	} cfg_t;

endpackage

FILE: src/midi_slot_record_play_control_top.sv
// a word accepted into the input stage passes through the result register to res_word
// throughput: one event per cycle while res_stall is low, slot state is updated as the event moves on
// the input stage holds while the result register is full and stalled
// reset: slots idle, no active play slot, passthrough set, registers at defaults
// (enable 1, channel 1, octave 0, record base 24, play base 36)
module midi_slot_record_play_control_top
	import mspc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              ev_valid,
	output logic              ev_stall,
	input  event_t            ev_word,
	output logic              res_valid,
	input  logic              res_stall,
	output result_t           res_word
);

	cfg_t    cfg_q;
	logic    ev_valid_s1;
	event_t  ev_s1;
	logic    out_valid_q;
	result_t out_word_q;
	result_t res_d;
	logic    adv;
	logic    wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable         <= 1'b1;
			cfg_q.listen_channel <= 5'd1;
			cfg_q.octave_shift   <= 4'd0;
			cfg_q.rec_note_base  <= 7'd24;
			cfg_q.play_note_base <= 7'd36;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLE:    cfg_q.enable         <= pwdata[0];
				REG_CHANNEL:   cfg_q.listen_channel <= pwdata[4:0];
				REG_OCTAVE:    cfg_q.octave_shift   <= pwdata[3:0];
				REG_REC_BASE:  cfg_q.rec_note_base  <= pwdata[6:0];
				REG_PLAY_BASE: cfg_q.play_note_base <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_ENABLE:    prdata = {31'd0, cfg_q.enable};
			REG_CHANNEL:   prdata = {27'd0, cfg_q.listen_channel};
			REG_OCTAVE:    prdata = {28'd0, cfg_q.octave_shift};
			REG_REC_BASE:  prdata = {25'd0, cfg_q.rec_note_base};
			REG_PLAY_BASE: prdata = {25'd0, cfg_q.play_note_base};
			default:       prdata = '0;
		endcase
	end

	// input stage moves on when the result register is free or being taken
	assign adv      = ev_valid_s1 && (!out_valid_q || !res_stall);
	assign ev_stall = ev_valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (ev_valid && !ev_stall) begin
			ev_valid_s1 <= 1'b1;
		end else if (adv) begin
			ev_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) ev_s1 <= ev_word;
	end

	// slot state and command decode
	mspc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ev     (ev_s1),
		.fire   (adv),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_word_q <= res_d;
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_word_q;

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_s1 && out_valid_q && res_stall |=> ev_valid_s1)
		else $error("input stage dropped a word under stall");

	a_start_play_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.start_play |->
			out_word_q.play_active && !out_word_q.passthrough &&
			(out_word_q.active_slot == out_word_q.play_slot))
		else $error("start_play without matching active slot");

	a_no_dual_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_word_q.start_play && out_word_q.start_rec))
		else $error("record and play started by one event");

	a_idle_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_word_q.play_active |-> out_word_q.active_slot == '0)
		else $error("active_slot set without play_active");
`endif

endmodule

FILE: src/mspc_core.sv
module mspc_core
	import mspc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  event_t  ev,
	input  logic    fire,
	output result_t res
);

	mode_t            mode_q [SLOT_COUNT];
	mode_t            mode_d [SLOT_COUNT];
	logic             pv_q, pv_d;
	slot_t            pi_q, pi_d;
	logic             lp_q, lp_d;

	logic                     hit_ch;
	logic                     on;
	logic signed [NOTE_W-1:0] oct_x;
	logic signed [NOTE_W-1:0] shift_notes;
	logic signed [NOTE_W-1:0] note_s;
	logic signed [NOTE_W-1:0] d_rec;
	logic signed [NOTE_W-1:0] d_play;
	logic                     rec_hit;
	logic                     play_hit;
	slot_t                    key;
	mode_t                    cur;

	localparam logic signed [NOTE_W-1:0] SLOTS_S = NOTE_W'(SLOT_COUNT);

	// event qualification and key range decode
	always_comb begin
		hit_ch      = cfg.enable && (ev.channel == cfg.listen_channel);
		on          = (ev.op == OP_NOTE_ON) && (ev.velocity != 7'd0);
		oct_x       = {{(NOTE_W-4){cfg.octave_shift[3]}}, cfg.octave_shift};
		shift_notes = (oct_x <<< 3) + (oct_x <<< 2);
		note_s      = signed'({{(NOTE_W-7){1'b0}}, ev.note_number}) + shift_notes;
		d_rec       = note_s - signed'({{(NOTE_W-7){1'b0}}, cfg.rec_note_base});
		d_play      = note_s - signed'({{(NOTE_W-7){1'b0}}, cfg.play_note_base});
		rec_hit     = !d_rec[NOTE_W-1] && (d_rec < SLOTS_S);
		play_hit    = !d_play[NOTE_W-1] && (d_play < SLOTS_S);
		key         = rec_hit ? d_rec[SLOT_W-1:0] : d_play[SLOT_W-1:0];
	end

	// mode of the key slot
	always_comb begin
		cur = MODE_IDLE;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (key == slot_t'(s)) cur = mode_q[s];
		end
	end

	// next slot state and command strobes
	always_comb begin
		mode_d = mode_q;
		pv_d   = pv_q;
		pi_d   = pi_q;
		lp_d   = lp_q;
		res    = '0;
		if (hit_ch && rec_hit) begin
			if (on) begin
				if (cur == MODE_IDLE || cur == MODE_ARMED) begin
					mode_d[key] = MODE_ARMED;
				end else if (cur == MODE_PLAY) begin
					res.stop_play = 1'b1;
					pv_d          = 1'b0;
					lp_d          = 1'b1;
					mode_d[key]   = MODE_REC;
					res.start_rec = 1'b1;
					res.rec_slot  = key;
				end
			end else begin
				if (cur == MODE_ARMED) begin
					mode_d[key] = MODE_IDLE;
				end else if (cur == MODE_REC) begin
					res.stop_rec = 1'b1;
					res.rec_slot = key;
					mode_d[key]  = MODE_IDLE;
				end
			end
		end else if (hit_ch && play_hit) begin
			if (on) begin
				if (!(pv_q && key < pi_q)) begin
					// displaced play slot goes idle, active flag is kept
					if (pv_q && pi_q != key) begin
						res.stop_play = 1'b1;
						for (int s = 0; s < SLOT_COUNT; s++) begin
							if (pi_q == slot_t'(s)) mode_d[s] = MODE_IDLE;
						end
					end
					if (cur == MODE_ARMED) begin
						mode_d[key]   = MODE_REC;
						res.start_rec = 1'b1;
						res.rec_slot  = key;
					end else begin
						mode_d[key]    = MODE_PLAY;
						pv_d           = 1'b1;
						pi_d           = key;
						res.start_play = 1'b1;
						res.play_slot  = key;
						lp_d           = 1'b0;
					end
				end
			end else begin
				if (cur == MODE_REC) begin
					res.stop_rec = 1'b1;
					res.rec_slot = key;
					mode_d[key]  = MODE_IDLE;
				end else if (cur == MODE_PLAY) begin
					res.stop_play = 1'b1;
					mode_d[key]   = MODE_IDLE;
					pv_d          = 1'b0;
					lp_d          = 1'b1;
				end
			end
		end
		res.play_active = pv_d;
		res.active_slot = pv_d ? pi_d : '0;
		res.passthrough = lp_d;
	end

	// slot state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) mode_q[s] <= MODE_IDLE;
			pv_q <= 1'b0;
			pi_q <= '0;
			lp_q <= 1'b1;
		end else if (fire) begin
			mode_q <= mode_d;
			pv_q   <= pv_d;
			pi_q   <= pi_d;
			lp_q   <= lp_d;
		end
	end

endmodule

FILE: dv/midi_slot_record_play_control_top_tb.sv
module midi_slot_record_play_control_top_tb;
	import mspc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OCTAVE_NOTES    = 12;
	localparam int TOTAL_WORDS     = 1150;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 4;
	localparam int CYCLE_LIMIT     = 500000;

	// register index with no register behind it
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              ev_valid;
	logic              ev_stall;
	event_t            ev_word;
	logic              res_valid;
	logic              res_stall;
	result_t           res_word;

	midi_slot_record_play_control_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_word  (ev_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word (res_word)
	);

	// shadow of the control registers and slot state
	cfg_t    live_cfg;
	mode_t   slot_modes [SLOT_COUNT];
	logic    play_on;
	slot_t   play_idx;
	logic    live_pass;

	result_t expected_cmds [$];
	int      words_sent;
	int      mismatches;
	int      cycle_count;
	bit      no_gaps;
	bit      no_stalls;
	bit      hold_off_req;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int shift_notes();
		return OCTAVE_NOTES * int'($signed(live_cfg.octave_shift));
	endfunction

	// apply one note event to the shadow state, return the command word it gives
	function automatic result_t apply_note_event(event_t e);
		result_t r;
		logic    key_on;
		int      note;
		int      rb;
		int      pb;
		slot_t   k;
		mode_t   cur;
		r = '0;
		if (live_cfg.enable && e.channel == live_cfg.listen_channel) begin
			key_on = (e.op == OP_NOTE_ON) && (e.velocity != 0);
			note   = int'(e.note_number) + shift_notes();
			rb     = int'(live_cfg.rec_note_base);
			pb     = int'(live_cfg.play_note_base);
			if (note >= rb && note < rb + SLOT_COUNT) begin
				// record key
				k   = slot_t'(note - rb);
				cur = slot_modes[k];
				if (key_on) begin
					if (cur == MODE_IDLE || cur == MODE_ARMED) begin
						slot_modes[k] = MODE_ARMED;
					end else if (cur == MODE_PLAY) begin
						r.stop_play   = 1'b1;
						play_on       = 1'b0;
						live_pass     = 1'b1;
						slot_modes[k] = MODE_REC;
						r.start_rec   = 1'b1;
						r.rec_slot    = k;
					end
				end else begin
					if (cur == MODE_ARMED) begin
						slot_modes[k] = MODE_IDLE;
					end else if (cur == MODE_REC) begin
						r.stop_rec    = 1'b1;
						r.rec_slot    = k;
						slot_modes[k] = MODE_IDLE;
					end
				end
			end else if (note >= pb && note < pb + SLOT_COUNT) begin
				// play key, higher active slot blocks lower ones
				k   = slot_t'(note - pb);
				cur = slot_modes[k];
				if (key_on) begin
					if (!(play_on && k < play_idx)) begin
						if (play_on && play_idx != k) begin
							r.stop_play          = 1'b1;
							slot_modes[play_idx] = MODE_IDLE;
						end
						// armed slot starts a take, displaced slot stays marked active
						if (cur == MODE_ARMED) begin
							slot_modes[k] = MODE_REC;
							r.start_rec   = 1'b1;
							r.rec_slot    = k;
						end else begin
							slot_modes[k] = MODE_PLAY;
							play_on       = 1'b1;
							play_idx      = k;
							r.start_play  = 1'b1;
							r.play_slot   = k;
							live_pass     = 1'b0;
						end
					end
				end else begin
					if (cur == MODE_REC) begin
						r.stop_rec    = 1'b1;
						r.rec_slot    = k;
						slot_modes[k] = MODE_IDLE;
					end else if (cur == MODE_PLAY) begin
						r.stop_play   = 1'b1;
						slot_modes[k] = MODE_IDLE;
						play_on       = 1'b0;
						live_pass     = 1'b1;
					end
				end
			end
		end
		r.play_active = play_on;
		r.active_slot = play_on ? play_idx : '0;
		r.passthrough = live_pass;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin : res_check
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_cmds.size() == 0) begin
				$error("result word with nothing expected: %h", res_word);
				mismatches++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("start_rec", want.start_rec, res_word.start_rec);
				check_field("stop_rec", want.stop_rec, res_word.stop_rec);
				check_field("rec_slot", want.rec_slot, res_word.rec_slot);
				check_field("stop_play", want.stop_play, res_word.stop_play);
				check_field("start_play", want.start_play, res_word.start_play);
				check_field("play_slot", want.play_slot, res_word.play_slot);
				check_field("play_active", want.play_active, res_word.play_active);
				check_field("active_slot", want.active_slot, res_word.active_slot);
				check_field("passthrough", want.passthrough, res_word.passthrough);
			end
		end
	end

	// result side stall pattern, with one long hold-off on request
	initial begin : res_side
		int r;
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (no_stalls || r < 50) begin
					res_stall <= 1'b0;
					n = $urandom_range(1, 8);
				end else if (r < 90) begin
					res_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					res_stall <= 1'b1;
					n = $urandom_range(10, 40);
				end
				// a hold-off request cuts the current stretch short
				repeat (n) begin
					@(negedge clk);
					if (hold_off_req)
						break;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one event word, hold it until accepted, then predict
	task automatic send_word(event_t ev);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			ev_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ev_valid <= 1'b1;
		ev_word  <= ev;
		do @(posedge clk); while (ev_stall);
		expected_cmds.push_back(apply_note_event(ev));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_note(logic op, int ch, int note, int vel);
		event_t ev;
		ev.op          = op;
		ev.channel     = ch[4:0];
		ev.note_number = note[6:0];
		ev.velocity    = vel[6:0];
		send_word(ev);
	endtask

	// stop offering and let every expected word come back
	task automatic wait_idle();
		ev_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// apb write: setup then access phase, then the bus returns to idle
	task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_ENABLE:    live_cfg.enable         = value[0];
		REG_CHANNEL:   live_cfg.listen_channel = value[4:0];
		REG_OCTAVE:    live_cfg.octave_shift   = value[3:0];
		REG_REC_BASE:  live_cfg.rec_note_base  = value[6:0];
		REG_PLAY_BASE: live_cfg.play_note_base = value[6:0];
		default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// press or release a record or play key of a slot under the current setup
	task automatic send_key(bit rec_key, int s, bit press);
		event_t ev;
		int     raw;
		raw = rec_key ? live_cfg.rec_note_base : live_cfg.play_note_base;
		raw = raw + s - shift_notes();
		if (raw < 0 || raw > 127)
			raw = $urandom_range(0, 127);
		ev.channel     = live_cfg.listen_channel;
		ev.note_number = raw[6:0];
		if (press) begin
			ev.op       = OP_NOTE_ON;
			ev.velocity = 7'($urandom_range(1, 127));
		end else if ($urandom_range(0, 2) == 0) begin
			ev.op       = OP_NOTE_ON;
			ev.velocity = '0;
		end else begin
			ev.op       = OP_NOTE_OFF;
			ev.velocity = 7'($urandom_range(0, 127));
		end
		send_word(ev);
	endtask

	// any event, mostly on the listened channel
	task automatic send_noise();
		event_t ev;
		ev.op          = 1'($urandom_range(0, 1));
		ev.channel     = ($urandom_range(0, 4) != 0) ? live_cfg.listen_channel
		                                             : 5'($urandom_range(0, 31));
		ev.note_number = 7'($urandom_range(0, 127));
		ev.velocity    = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
		send_word(ev);
	endtask

	// short key sequences as a player would use them
	task automatic send_phrase();
		int s;
		s = $urandom_range(0, SLOT_COUNT - 1);
		case ($urandom_range(0, 4))
		0: begin
			// arm, take, stop take
			send_key(1, s, 1);
			send_key(0, s, 1);
			send_key(0, s, 0);
		end
		1: begin
			// play, maybe switch, release
			send_key(0, s, 1);
			if ($urandom_range(0, 1))
				send_key(0, $urandom_range(0, SLOT_COUNT - 1), 1);
			send_key(0, s, 0);
		end
		2: begin
			// punch into a playing slot
			send_key(0, s, 1);
			send_key(1, s, 1);
			send_key(1, s, 0);
		end
		3: begin
			send_key(1, s, 1);
			send_key(1, s, 0);
		end
		default: send_key(1'($urandom_range(0, 1)), s, 1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic send_mix(int n);
		repeat (n) begin
			if ($urandom_range(0, 9) < 7)
				send_phrase();
			else
				send_noise();
		end
	endtask

	// directed walk through the slot modes at reset settings
	task automatic test_slot_modes();
		send_note(OP_NOTE_ON, 1, 24, 100);
		send_note(OP_NOTE_ON, 1, 36, 127);
		send_note(OP_NOTE_OFF, 1, 36, 0);
		send_note(OP_NOTE_ON, 1, 41, 1);
		send_note(OP_NOTE_ON, 1, 39, 64);
		send_note(OP_NOTE_ON, 1, 29, 64);
		send_note(OP_NOTE_OFF, 1, 29, 64);
		send_note(OP_NOTE_ON, 1, 41, 90);
		send_note(OP_NOTE_ON, 1, 32, 90);
		// play key on an armed slot while another slot plays
		send_note(OP_NOTE_ON, 1, 44, 90);
		send_note(OP_NOTE_ON, 1, 47, 90);
		// note on with zero velocity releases
		send_note(OP_NOTE_ON, 1, 47, 0);
		send_note(OP_NOTE_ON, 1, 47, 127);
		send_note(OP_NOTE_OFF, 1, 47, 64);
		send_note(OP_NOTE_ON, 1, 25, 10);
		send_note(OP_NOTE_OFF, 1, 25, 127);
		// other channels are dropped
		send_note(OP_NOTE_ON, 2, 24, 100);
		send_note(OP_NOTE_ON, 0, 36, 100);
		send_note(OP_NOTE_ON, 31, 127, 127);
		// keys outside both ranges, then a play key release
		send_note(OP_NOTE_ON, 1, 0, 127);
		send_note(OP_NOTE_OFF, 1, 127, 127);
		send_note(OP_NOTE_ON, 1, 48, 50);
		send_note(OP_NOTE_ON, 1, 23, 50);
		send_note(OP_NOTE_OFF, 1, 44, 0);
		wait_idle();
	endtask

	// register extremes: disabled, channel 16, octave -4 and +4, base limits, overlap
	task automatic test_register_extremes();
		cfg_write(REG_ENABLE, 0);
		send_mix(6);
		wait_idle();
		cfg_write(REG_ENABLE, 1);
		cfg_write(REG_CHANNEL, 16);
		cfg_write(REG_OCTAVE, 32'hC);       // -4 octaves
		cfg_write(REG_REC_BASE, 0);
		cfg_write(REG_PLAY_BASE, 12);
		send_mix(12);
		wait_idle();
		// shifted notes above 127 still reach a base at the top
		cfg_write(REG_OCTAVE, 4);
		cfg_write(REG_REC_BASE, 127);
		cfg_write(REG_PLAY_BASE, 115);
		send_mix(12);
		wait_idle();
		// identical ranges, record keys win
		cfg_write(REG_OCTAVE, 0);
		cfg_write(REG_REC_BASE, 60);
		cfg_write(REG_PLAY_BASE, 60);
		send_mix(10);
		wait_idle();
		cfg_write(REG_PLAY_BASE, 66);
		send_mix(10);
		wait_idle();
		// write to an unmapped index has no effect
		cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
		send_mix(8);
		wait_idle();
		cfg_write(REG_CHANNEL, 1);
		cfg_write(REG_REC_BASE, 24);
		cfg_write(REG_PLAY_BASE, 36);
	endtask

	// receiver holds off long while words keep coming
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		no_gaps      = 1'b1;
		send_mix(15);
		no_gaps      = 1'b0;
		wait_idle();
	endtask

	task automatic randomize_setup();
		int rb;
		wait_idle();
		rb = $urandom_range(0, 127);
		cfg_write(REG_ENABLE, ($urandom_range(0, 19) != 0));
		cfg_write(REG_CHANNEL, $urandom_range(1, 16));
		cfg_write(REG_OCTAVE, ($urandom_range(0, 8) + 12) & 32'hF);
		cfg_write(REG_REC_BASE, rb);
		if ($urandom_range(0, 2) == 0)
			cfg_write(REG_PLAY_BASE, (rb + $urandom_range(0, 24)) & 32'h7F);
		else
			cfg_write(REG_PLAY_BASE, $urandom_range(0, 127));
		no_gaps   = ($urandom_range(0, 4) == 0);
		no_stalls = ($urandom_range(0, 4) == 0);
	endtask

	task automatic test_random_traffic();
		while (words_sent < TOTAL_WORDS) begin
			randomize_setup();
			send_mix(40);
		end
		no_gaps   = 1'b0;
		no_stalls = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		ev_valid     = 1'b0;
		ev_word      = '0;
		res_stall    = 1'b0;
		words_sent   = 0;
		mismatches   = 0;
		cycle_count  = 0;
		no_gaps      = 1'b0;
		no_stalls    = 1'b0;
		hold_off_req = 1'b0;
		live_cfg     = '{enable: 1'b1, listen_channel: 5'd1, octave_shift: 4'd0,
		                 rec_note_base: 7'd24, play_note_base: 7'd36};
		foreach (slot_modes[i])
			slot_modes[i] = MODE_IDLE;
		play_on   = 1'b0;
		play_idx  = '0;
		live_pass = 1'b1;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_slot_modes();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
